// ===== rtl/alq_pkg.sv =====
// Package for the axis level quantizer: field widths, register indexes,
// reset values and the sequencer state type. No dependencies.

package alq_pkg;

  localparam int MAX_LEVELS_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int LEVEL_W   = 6;
  localparam int COUNT_W   = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_END_FIRST    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_VALUE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_SECOND   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT  = 2'd3;

  localparam logic [COUNT_W-1:0] LEVEL_COUNT_RST = 5'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_LOAD_L,
    ST_LEFT,
    ST_MUL_R,
    ST_LOAD_R,
    ST_RIGHT,
    ST_FINISH
  } alq_state_e;

endpackage

// ===== rtl/axis_level_quantizer_unit.sv =====
// Axis level quantizer: maps one raw axis sample to a signed level -N..+N.
// Depends on alq_pkg.
//
//   channel   direction  handshake                       payload
//   cfg       in         cfg_we_i                        cfg_idx_i, cfg_data_i
//   sample    in         sample_valid_i / sample_stall_o sample_i
//   level     out        level_valid_o / level_stall_i   level_o
//
// A sample inside the span with N levels runs two multiply/load pairs plus N
// compare-and-add steps per side on the shared accumulator before the finish
// step; clamped samples and N = 0 go straight from acceptance to the finish
// step. No new word is taken until the current one has left the finish step.
// Reset clears the sequencer, the output valid and the configuration
// registers to their defaults. The result register frees the sequencer, so a
// stalled output word blocks input only once the next result is ready.

module axis_level_quantizer_unit
  import alq_pkg::*;
#(
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]        cfg_data_i,
  input  logic                          sample_valid_i,
  output logic                          sample_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          level_valid_o,
  input  logic                          level_stall_i,
  output logic signed [LEVEL_W-1:0]     level_o
);

  localparam int NW     = $clog2(MAX_LEVELS + 1);
  localparam int DEN_W  = NW + 1;
  localparam int DIF_W  = SAMPLE_BITS + 1;
  localparam int PROD_W = DIF_W + DEN_W + 1;
  localparam int ACC_W  = SAMPLE_BITS + DEN_W + 4;
  localparam int LV_W   = (NW + 2 > LEVEL_W) ? NW + 2 : LEVEL_W;

  alq_state_e state_q, state_d;

  logic signed [SAMPLE_BITS-1:0] end_first_q, center_q, end_second_q;
  logic [COUNT_W-1:0]            count_q;

  logic signed [DIF_W-1:0]  d_lo_q, d_c_q, dl_q, dr_q;
  logic                     s_np_q, back_q;
  logic [NW-1:0]            n_q, cnt_q;
  logic signed [LV_W-1:0]   lvl_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     level_valid_q;
  logic signed [LEVEL_W-1:0] level_q;

  logic                          take, out_load, cnt_last, in_range, back;
  logic signed [SAMPLE_BITS-1:0] lo, hi;
  logic [NW-1:0]                 n_sel;
  logic signed [LV_W-1:0]        nx_lv, n_lv, lvl_init, lvl_fin;
  logic [DEN_W-1:0]              den;
  logic signed [PROD_W-1:0]      mul_a, mul_b, prod_d;
  logic signed [ACC_W-1:0]       acc_base, acc_den, acc_off, acc_load, acc_step;
  logic                          hit;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_first_q  <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      center_q     <= '0;
      end_second_q <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      count_q      <= LEVEL_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_END_FIRST:    end_first_q  <= cfg_data_i;
        REG_CENTER_VALUE: center_q     <= cfg_data_i;
        REG_END_SECOND:   end_second_q <= cfg_data_i;
        REG_LEVEL_COUNT:  count_q      <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // accept-time decode
  always_comb begin
    back  = end_first_q > end_second_q;
    lo    = back ? end_second_q : end_first_q;
    hi    = back ? end_first_q : end_second_q;
    n_sel = (32'(count_q) > MAX_LEVELS) ? NW'(MAX_LEVELS) : NW'(count_q);
    nx_lv = $signed(LV_W'(n_sel));
    in_range = 1'b0;
    priority if (n_sel == '0) begin
      lvl_init = '0;
    end else if (sample_i < lo) begin
      lvl_init = -nx_lv;
    end else if (sample_i > hi) begin
      lvl_init = nx_lv;
    end else begin
      lvl_init = -nx_lv;
      in_range = 1'b1;
    end
  end

  // shared multiplier and accumulator
  always_comb begin
    den      = {n_q, 1'b1};
    n_lv     = $signed(LV_W'(n_q));
    mul_a    = PROD_W'((state_q == ST_MUL_L) ? d_lo_q : d_c_q);
    mul_b    = $signed(PROD_W'(den));
    prod_d   = mul_a * mul_b;
    acc_base = ACC_W'(prod_q) <<< 1;
    acc_den  = $signed(ACC_W'(den));
    acc_off  = (state_q == ST_LOAD_L) ? (ACC_W'(dl_q) <<< 2) : (ACC_W'(dr_q) <<< 1);
    acc_load = acc_base + acc_den + acc_off;
    acc_step = (state_q == ST_LEFT) ? (ACC_W'(dl_q) <<< 2) : (ACC_W'(dr_q) <<< 2);
    hit      = acc_q[ACC_W-1] || ((acc_q == '0) && s_np_q);
    lvl_fin  = back_q ? -lvl_q : lvl_q;
    cnt_last = (cnt_q == (n_q - NW'(1)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    take     = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (sample_valid_i) begin
          take    = 1'b1;
          state_d = in_range ? ST_MUL_L : ST_FINISH;
        end
      end
      ST_MUL_L:  state_d = ST_LOAD_L;
      ST_LOAD_L: state_d = ST_LEFT;
      ST_LEFT: begin
        if (cnt_last) state_d = ST_MUL_R;
      end
      ST_MUL_R:  state_d = ST_LOAD_R;
      ST_LOAD_R: state_d = ST_RIGHT;
      ST_RIGHT: begin
        if (cnt_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!level_valid_q || !level_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          d_lo_q <= DIF_W'(lo) - DIF_W'(sample_i);
          d_c_q  <= DIF_W'(center_q) - DIF_W'(sample_i);
          dl_q   <= DIF_W'(center_q) - DIF_W'(lo);
          dr_q   <= DIF_W'(hi) - DIF_W'(center_q);
          s_np_q <= sample_i[SAMPLE_BITS-1] || (sample_i == '0);
          n_q    <= n_sel;
          back_q <= back;
          lvl_q  <= lvl_init;
          cnt_q  <= '0;
        end
      end
      ST_MUL_L, ST_MUL_R: prod_q <= prod_d;
      ST_LOAD_L, ST_LOAD_R: begin
        acc_q <= acc_load;
        cnt_q <= '0;
      end
      ST_LEFT, ST_RIGHT: begin
        acc_q <= acc_q + acc_step;
        lvl_q <= lvl_q + $signed({{(LV_W-1){1'b0}}, hit});
        cnt_q <= cnt_last ? '0 : cnt_q + NW'(1);
      end
      ST_FINISH: begin
        if (out_load) level_q <= lvl_fin[LEVEL_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_valid_q <= 1'b0;
    end else if (out_load) begin
      level_valid_q <= 1'b1;
    end else if (!level_stall_i) begin
      level_valid_q <= 1'b0;
    end
  end

  assign sample_stall_o = (state_q != ST_IDLE);
  assign level_valid_o  = level_valid_q;
  assign level_o        = level_q;

`ifndef ASSERT_OFF
  a_take_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (state_q == ST_MUL_L || state_q == ST_FINISH))
    else $error("accepted word did not start the sequencer");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LEFT || state_q == ST_RIGHT) |-> (cnt_q < n_q))
    else $error("step counter ran past the level count");

  a_lvl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LEFT || state_q == ST_RIGHT || state_q == ST_FINISH)
      |-> (lvl_q <= n_lv && lvl_q >= -n_lv))
    else $error("level left the range -N..N");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_valid_o && !$past(level_valid_o)) |-> $past(state_q == ST_FINISH))
    else $error("output word raised outside the finish step");
`endif

endmodule
